// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the pulse timer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PMT_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PMT_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// shared types and constants of the multi channel pulse timer
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_EVENTS  = 8;
    localparam int EV_CNT_W    = $clog2(MAX_EVENTS);
    localparam int TIME_W      = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [7:0] SUBTICKS_RESET = 8'd5;
    localparam logic [9:0] MS_PER_S       = 10'd1000;
    localparam logic [5:0] S_PER_MIN      = 6'd60;

    // event kinds on the result channel
    localparam logic EV_START = 1'b0;
    localparam logic EV_END   = 1'b1;

    // request function codes
    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_LOAD    = 3'd1,
        FUNC_START   = 3'd2,
        FUNC_STOP    = 3'd3,
        FUNC_RESTART = 3'd4,
        FUNC_SET_DUR = 3'd5
    } func_t;

    // classified commands handed to the execution side
    typedef enum logic [2:0] {
        OP_STEP,
        OP_LOAD,
        OP_START,
        OP_STOP,
        OP_RESTART,
        OP_SET_DUR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [CH_IDX_W-1:0]   ch;
        logic [TIME_W-1:0]     dur;
        logic                  start_now;
        logic                  report_end;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SCAN,
        BK_SCAN_EMIT,
        BK_EMIT_FIRST,
        BK_EMIT_SECOND
    } back_state_t;

endpackage

// File: rtl/multi_channel_pulse_timer_top.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_timer_top
// bank of one-shot pulse timers with a shared millisecond prescaler
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   command  | cmd_valid, cmd_stall | func, channel, duration_*, start_now,
//            |                      | report_end
//   event    | evt_valid, evt_stall | event_kind, event_channel, last
//   config   | cfg_we               | cfg_data (subticks_per_ms)
//
// a command request goes through the front in its accept cycle, waits in a
// two-entry queue, then passes the idle and exec states of the execution fsm
// and an emit state per event; a tick that completes a millisecond scans one
// channel per cycle through the single bank read port, then walks the
// channels again to send the end events, at most one per cycle while the
// event output is not stalled; rst_n clears all timers, the prescaler and
// the queue at once; stalls on the event side back up into the queue;
// cmd_stall rises only when the queue is full
// ----------------------------------------------------------------------------
module multi_channel_pulse_timer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  func,
    input  logic [2:0]  channel,
    input  logic [7:0]  duration_minutes,
    input  logic [5:0]  duration_seconds,
    input  logic [9:0]  duration_millis,
    input  logic        start_now,
    input  logic        report_end,
    output logic        evt_valid,
    input  logic        evt_stall,
    output logic        event_kind,
    output logic [2:0]  event_channel,
    output logic        last
);
    import pmt_pkg::*;

    // front to queue
    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;

    // queue to execution side
    logic q_pop;
    cmd_t q_pop_cmd;
    logic q_empty;

    // classification and prescaler: ticks that do not finish a millisecond,
    // unused codes and unknown channels never reach the queue
    pmt_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .func             (func),
        .channel          (channel),
        .duration_minutes (duration_minutes),
        .duration_seconds (duration_seconds),
        .duration_millis  (duration_millis),
        .start_now        (start_now),
        .report_end       (report_end),
        .q_push           (q_push),
        .q_cmd            (q_push_cmd),
        .q_full           (q_full)
    );

    // decouples the request side from the event side
    pmt_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // channel bank, millisecond scan and event output register
    pmt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (q_pop_cmd),
        .q_pop         (q_pop),
        .evt_valid     (evt_valid),
        .evt_stall     (evt_stall),
        .event_kind    (event_kind),
        .event_channel (event_channel),
        .last          (last)
    );

endmodule

// File: rtl/pmt_front.sv
// ----------------------------------------------------------------------------
// pmt_front
// accepts requests, runs the prescaler and queues classified commands
// ----------------------------------------------------------------------------
module pmt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [2:0]        func,
    input  logic [2:0]        channel,
    input  logic [7:0]        duration_minutes,
    input  logic [5:0]        duration_seconds,
    input  logic [9:0]        duration_millis,
    input  logic              start_now,
    input  logic              report_end,
    output logic              q_push,
    output pmt_pkg::cmd_t     q_cmd,
    input  logic              q_full
);
    import pmt_pkg::*;

    logic [7:0] subticks_reg;
    logic [7:0] prescale_reg;
    logic [7:0] prescale_next;
    logic [7:0] prescale_inc;
    logic       accept;
    logic       ch_ok;
    logic       step_hit;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;

    always_comb
    begin
        prescale_inc     = prescale_reg + 8'd1;
        step_hit         = (prescale_inc == subticks_reg);
        ch_ok            = (32'(channel) < CHANNELS);
        prescale_next    = prescale_reg;
        q_push           = 1'b0;
        q_cmd.op         = OP_STEP;
        q_cmd.ch         = CH_IDX_W'(channel);
        q_cmd.dur        = {duration_minutes, duration_seconds, duration_millis};
        q_cmd.start_now  = start_now;
        q_cmd.report_end = report_end;
        if (accept)
        begin
            unique case (func)
                FUNC_TICK:
                begin
                    // wraps at 256, so a zero register still steps
                    prescale_next = step_hit ? 8'd0 : prescale_inc;
                    q_push        = step_hit;
                end
                FUNC_LOAD:
                begin
                    q_cmd.op = OP_LOAD;
                    q_push   = ch_ok;
                end
                FUNC_START:
                begin
                    q_cmd.op = OP_START;
                    q_push   = ch_ok;
                end
                FUNC_STOP:
                begin
                    q_cmd.op = OP_STOP;
                    q_push   = ch_ok;
                end
                FUNC_RESTART:
                begin
                    q_cmd.op = OP_RESTART;
                    q_push   = ch_ok;
                end
                FUNC_SET_DUR:
                begin
                    q_cmd.op = OP_SET_DUR;
                    q_push   = ch_ok;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subticks_reg <= SUBTICKS_RESET;
            prescale_reg <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                subticks_reg <= cfg_data;
            end
            prescale_reg <= prescale_next;
        end
    end

endmodule

// File: rtl/pmt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pmt_cmd_fifo
// short command queue between the front and the execution side
// ----------------------------------------------------------------------------
module pmt_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pmt_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output pmt_pkg::cmd_t     pop_cmd,
    output logic              empty
);
    import pmt_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/pmt_back.sv
// ----------------------------------------------------------------------------
// pmt_back
// executes commands on the channel bank and sends out events
// ----------------------------------------------------------------------------
module pmt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pmt_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              evt_valid,
    input  logic              evt_stall,
    output logic              event_kind,
    output logic [2:0]        event_channel,
    output logic              last
);
    import pmt_pkg::*;

    localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(CHANNELS - 1);

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg;
    logic                cmd_load;
    logic [CH_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CHANNELS-1:0] ends_reg, ends_next;
    logic [CHANNELS-1:0] ends_left;
    logic [EV_CNT_W-1:0] ev_cnt_reg, ev_cnt_next;
    logic                first_kind_reg, first_kind_next;
    logic                two_reg, two_next;

    logic [CHANNELS-1:0] active_reg;
    logic [TIME_W-1:0]   elapsed_reg [CHANNELS];
    logic [TIME_W-1:0]   dur_reg [CHANNELS];

    logic [CH_IDX_W-1:0] rd_idx;
    logic [TIME_W-1:0]   cur_el;
    logic [TIME_W-1:0]   cur_dur;
    logic                cur_act;
    logic [9:0]          ms_inc;
    logic [5:0]          sec_inc;
    logic [7:0]          min_inc;
    logic [TIME_W-1:0]   step_time;

    logic                el_we;
    logic [TIME_W-1:0]   el_wdata;
    logic                dur_we;
    logic                act_we;
    logic                act_wdata;

    logic                out_free;
    logic                evt_load;
    logic                evt_kind_in;
    logic [2:0]          evt_ch_in;
    logic                evt_last_in;
    logic                evt_valid_reg;
    logic                event_kind_reg;
    logic [2:0]          event_channel_reg;
    logic                last_reg;

    assign evt_valid     = evt_valid_reg;
    assign event_kind    = event_kind_reg;
    assign event_channel = event_channel_reg;
    assign last          = last_reg;
    assign out_free      = !evt_valid_reg || !evt_stall;

    // single read port into the channel bank
    assign rd_idx  = (state_reg == BK_SCAN) ? scan_idx_reg : cmd_reg.ch;
    assign cur_el  = elapsed_reg[rd_idx];
    assign cur_dur = dur_reg[rd_idx];
    assign cur_act = active_reg[rd_idx];

    // one millisecond with carry into seconds and minutes
    always_comb
    begin
        ms_inc  = cur_el[9:0] + 10'd1;
        sec_inc = cur_el[15:10];
        min_inc = cur_el[23:16];
        if (ms_inc == MS_PER_S)
        begin
            ms_inc  = 10'd0;
            sec_inc = sec_inc + 6'd1;
            if (sec_inc == S_PER_MIN)
            begin
                sec_inc = 6'd0;
                min_inc = min_inc + 8'd1;
            end
        end
        step_time = {min_inc, sec_inc, ms_inc};
    end

    always_comb
    begin
        state_next      = state_reg;
        q_pop           = 1'b0;
        cmd_load        = 1'b0;
        scan_idx_next   = scan_idx_reg;
        ends_next       = ends_reg;
        ev_cnt_next     = ev_cnt_reg;
        first_kind_next = first_kind_reg;
        two_next        = two_reg;
        el_we           = 1'b0;
        el_wdata        = '0;
        dur_we          = 1'b0;
        act_we          = 1'b0;
        act_wdata       = 1'b0;
        evt_load        = 1'b0;
        evt_kind_in     = EV_START;
        evt_ch_in       = 3'(cmd_reg.ch);
        evt_last_in     = 1'b0;
        ends_left       = ends_reg;
        ends_left[scan_idx_reg] = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_load   = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                two_next = 1'b0;
                unique case (cmd_reg.op)
                    OP_STEP:
                    begin
                        scan_idx_next = '0;
                        ends_next     = '0;
                        state_next    = BK_SCAN;
                    end
                    OP_LOAD:
                    begin
                        dur_we          = 1'b1;
                        el_we           = 1'b1;
                        act_we          = 1'b1;
                        act_wdata       = cmd_reg.start_now;
                        first_kind_next = EV_START;
                        state_next      = cmd_reg.start_now ? BK_EMIT_FIRST : BK_IDLE;
                    end
                    OP_START:
                    begin
                        el_we           = 1'b1;
                        act_we          = 1'b1;
                        act_wdata       = 1'b1;
                        first_kind_next = EV_START;
                        state_next      = BK_EMIT_FIRST;
                    end
                    OP_STOP:
                    begin
                        el_we           = 1'b1;
                        act_we          = 1'b1;
                        act_wdata       = 1'b0;
                        first_kind_next = EV_END;
                        state_next      = cmd_reg.report_end ? BK_EMIT_FIRST : BK_IDLE;
                    end
                    OP_RESTART:
                    begin
                        el_we           = 1'b1;
                        act_we          = 1'b1;
                        act_wdata       = 1'b1;
                        first_kind_next = EV_END;
                        two_next        = 1'b1;
                        state_next      = BK_EMIT_FIRST;
                    end
                    OP_SET_DUR:
                    begin
                        dur_we          = 1'b1;
                        first_kind_next = EV_END;
                        if (cur_act)
                        begin
                            el_we      = 1'b1;
                            act_we     = 1'b1;
                            act_wdata  = 1'b0;
                            state_next = BK_EMIT_FIRST;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_SCAN:
            begin
                if (cur_act)
                begin
                    el_we = 1'b1;
                    if (step_time == cur_dur)
                    begin
                        el_wdata                = '0;
                        act_we                  = 1'b1;
                        act_wdata               = 1'b0;
                        ends_next[scan_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        el_wdata = step_time;
                    end
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    ev_cnt_next   = '0;
                    state_next    = BK_SCAN_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            BK_SCAN_EMIT:
            begin
                if (ends_reg == '0)
                begin
                    state_next = BK_IDLE;
                end
                else if (ends_reg[scan_idx_reg])
                begin
                    if (out_free)
                    begin
                        evt_load    = 1'b1;
                        evt_kind_in = EV_END;
                        evt_ch_in   = 3'(scan_idx_reg);
                        // end of list, or event cap reached
                        evt_last_in = (ends_left == '0)
                                   || (ev_cnt_reg == EV_CNT_W'(MAX_EVENTS - 1));
                        ev_cnt_next = ev_cnt_reg + 1'b1;
                        if (evt_last_in)
                        begin
                            ends_next  = '0;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            ends_next     = ends_left;
                            scan_idx_next = scan_idx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            BK_EMIT_FIRST:
            begin
                if (out_free)
                begin
                    evt_load    = 1'b1;
                    evt_kind_in = first_kind_reg;
                    evt_last_in = !two_reg;
                    state_next  = two_reg ? BK_EMIT_SECOND : BK_IDLE;
                end
            end
            BK_EMIT_SECOND:
            begin
                if (out_free)
                begin
                    evt_load    = 1'b1;
                    evt_kind_in = EV_START;
                    evt_last_in = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            scan_idx_reg   <= '0;
            ends_reg       <= '0;
            ev_cnt_reg     <= '0;
            first_kind_reg <= EV_START;
            two_reg        <= 1'b0;
            active_reg     <= '0;
            evt_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                elapsed_reg[i] <= '0;
                dur_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            ends_reg       <= ends_next;
            ev_cnt_reg     <= ev_cnt_next;
            first_kind_reg <= first_kind_next;
            two_reg        <= two_next;
            if (el_we)
            begin
                elapsed_reg[rd_idx] <= el_wdata;
            end
            if (dur_we)
            begin
                dur_reg[rd_idx] <= cmd_reg.dur;
            end
            if (act_we)
            begin
                active_reg[rd_idx] <= act_wdata;
            end
            if (evt_load)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= q_cmd;
        end
        if (evt_load)
        begin
            event_kind_reg    <= evt_kind_in;
            event_channel_reg <= evt_ch_in;
            last_reg          <= evt_last_in;
        end
    end

endmodule

// File: rtl/pmt_checker.sv
// ----------------------------------------------------------------------------
// pmt_checker
// port level checks of the pulse timer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic        evt_valid,
    input  logic        evt_stall,
    input  logic        event_kind,
    input  logic [2:0]  event_channel,
    input  logic        last
);
    import pmt_pkg::*;

    logic seen_cmd_reg;
    logic seen_cmd_next;

    assign seen_cmd_next = seen_cmd_reg || (cmd_valid && !cmd_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_cmd_reg <= 1'b0;
        end
        else
        begin
            seen_cmd_reg <= seen_cmd_next;
        end
    end

    `PMT_ASSERT_NXT(a_evt_hold, evt_valid && evt_stall, evt_valid, "event dropped while stalled")
    `PMT_ASSERT_NXT(a_evt_stable, evt_valid && evt_stall, $stable(event_kind) && $stable(event_channel) && $stable(last), "event changed while stalled")
    `PMT_ASSERT_IMP(a_start_last, evt_valid && (event_kind == EV_START), last, "start event not last of its request")
    `PMT_ASSERT_IMP(a_no_spurious, evt_valid, seen_cmd_reg, "event before any request")

endmodule

bind multi_channel_pulse_timer_top pmt_checker u_pmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .evt_valid     (evt_valid),
    .evt_stall     (evt_stall),
    .event_kind    (event_kind),
    .event_channel (event_channel),
    .last          (last)
);
